// ===== src/bop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bop_pkg
// Shared types, object codes and the object length table for the BTHome v2
// object parser.
// ----------------------------------------------------------------------------
package bop_pkg;

   // device-info byte for version 2, unencrypted
   localparam logic [7:0] HdrPlainV2  = 8'h40;
   // first object type that is not understood
   localparam logic [7:0] TypeLimit   = 8'h61;
   // length code meaning the first data byte carries the length
   localparam logic [3:0] LenVariable = 4'd15;

   // measurement object types
   localparam logic [7:0] TypeBattery    = 8'h01;
   localparam logic [7:0] TypeTemp       = 8'h02;
   localparam logic [7:0] TypeHumid      = 8'h03;
   localparam logic [7:0] TypeVolt       = 8'h0C;
   localparam logic [7:0] TypeHumidU8    = 8'h2E;
   localparam logic [7:0] TypeTempX10    = 8'h45;
   localparam logic [7:0] TypeTempS8     = 8'h57;
   localparam logic [7:0] TypeTempS8X35  = 8'h58;

   // quantity codes
   localparam logic [1:0] QtyTemp    = 2'd0;
   localparam logic [1:0] QtyHumid   = 2'd1;
   localparam logic [1:0] QtyBattery = 2'd2;
   localparam logic [1:0] QtyVolt    = 2'd3;

   // packet status codes
   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusBadHeader = 2'd1;
   localparam logic [1:0] StatusUnknown   = 2'd2;
   localparam logic [1:0] StatusTruncated = 2'd3;

   // data bytes per object type
   localparam logic [3:0] ObjLenTable [0:96] = '{
      4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2,
      4'd2, 4'd1, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1,
      4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 4'd2, 4'd4, 4'd2,
      4'd2, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd4, 4'd2, 4'd2, 4'd15, 4'd15, 4'd4, 4'd2, 4'd1,
      4'd1, 4'd1, 4'd2, 4'd4, 4'd4, 4'd2, 4'd2, 4'd2,
      4'd1
   };

   // decoded measurement of one completed object
   typedef struct packed {
      logic        hit;
      logic [1:0]  qty;
      logic [15:0] value;
   } meas_type;

   function automatic logic [3:0] obj_len(input logic [7:0] obj_type);
      logic [3:0] len;
      len = 4'd0;
      if (obj_type < TypeLimit) begin
         len = ObjLenTable[obj_type[6:0]];
      end
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== src/bop_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bop_decode
// Turns a completed object into a scaled 16-bit measurement, or no hit for
// types that carry no temperature, humidity, battery or voltage.
// ----------------------------------------------------------------------------
module bop_decode (
   input  wire logic [7:0]       obj_type,
   input  wire logic [15:0]      obj_data,
   output bop_pkg::meas_type     meas
);

   logic [15:0] sext_lo;
   logic [26:0] div_prod;

   assign sext_lo  = {{8{obj_data[7]}}, obj_data[7:0]};
   // d / 100 == (d >> 2) / 25, reciprocal 5243 / 2^17 is exact over 14 bits
   assign div_prod = 27'(obj_data[15:2]) * 27'd5243;

   always_comb begin
      meas = '0;
      case (obj_type)
         bop_pkg::TypeTemp: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyTemp, value: obj_data};
         end
         bop_pkg::TypeTempX10: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyTemp, value: 16'(obj_data * 16'd10)};
         end
         bop_pkg::TypeTempS8: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyTemp, value: 16'(sext_lo * 16'd100)};
         end
         bop_pkg::TypeTempS8X35: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyTemp, value: 16'(sext_lo * 16'd35)};
         end
         bop_pkg::TypeHumid: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyHumid, value: obj_data};
         end
         bop_pkg::TypeHumidU8: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyHumid,
                     value: 16'({8'b0, obj_data[7:0]} * 16'd100)};
         end
         bop_pkg::TypeBattery: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyBattery, value: {8'b0, obj_data[7:0]}};
         end
         bop_pkg::TypeVolt: begin
            meas = '{hit: 1'b1, qty: bop_pkg::QtyVolt, value: {6'b0, div_prod[26:17]}};
         end
         default: begin
            meas = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/bthome_object_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bthome_object_parser
// Splits a BTHome v2 service-data payload, one byte per beat, into objects
// and gives one result per completed measurement object and per packet end.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            beat
//  req_     in   req_valid/req_stall  one payload byte with packet marks, slot
//  rsp_     out  rsp_valid/rsp_stall  measurement update and/or packet end
//
//  one byte per cycle unless rsp_stall holds a waiting result; a result leaves
//  through the input register, then the result register
//  bytes that complete no object and carry no end mark give no result beat
//  reset clears the pipeline and the parser state; no clearing pass
//  rsp_stall holds the result register and, with a byte waiting behind it,
//  raises req_stall in the same cycle
// ----------------------------------------------------------------------------
module bthome_object_parser #(
   parameter int unsigned SLOT_COUNT = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic [1:0]  req_sensor_slot,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_update_valid,
   output logic [1:0]       rsp_update_slot,
   output logic [1:0]       rsp_quantity,
   output logic [15:0]      rsp_measured_value,
   output logic             rsp_packet_end,
   output logic [1:0]       rsp_packet_status
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff, in_last_ff;
   logic [1:0]  in_slot_ff;

   // parser state
   logic        hdr_ok_ff, hdr_ok_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  obj_type_ff, obj_type_in;
   logic [8:0]  obj_len_ff, obj_len_in;
   logic [8:0]  obj_cnt_ff, obj_cnt_in;
   logic [15:0] obj_data_ff, obj_data_in;
   logic [1:0]  end_status_ff, end_status_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_upd_ff;
   logic [1:0]  out_slot_ff;
   logic [1:0]  out_qty_ff;
   logic [15:0] out_value_ff;
   logic        out_end_ff;
   logic [1:0]  out_status_ff;

   logic              out_blocked;
   logic              advance;
   logic              req_take;
   logic              upd;
   logic              emit;
   logic [1:0]        status;
   logic [3:0]        type_len;
   logic [8:0]        cnt_next;
   bop_pkg::meas_type meas;

   assign out_blocked = out_valid_ff & rsp_stall;
   assign advance     = in_valid_ff & ~out_blocked;
   assign req_stall   = in_valid_ff & out_blocked;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   assign type_len = bop_pkg::obj_len(in_byte_ff);
   assign cnt_next = obj_cnt_ff + 9'd1;

   bop_decode u_decode (
      .obj_type (obj_type_ff),
      .obj_data (obj_data_in),
      .meas     (meas)
   );

   always_comb begin
      hdr_ok_in     = hdr_ok_ff;
      stopped_in    = stopped_ff;
      obj_type_in   = obj_type_ff;
      obj_len_in    = obj_len_ff;
      obj_cnt_in    = obj_cnt_ff;
      obj_data_in   = obj_data_ff;
      end_status_in = end_status_ff;
      upd           = 1'b0;
      status        = bop_pkg::StatusOk;

      if (in_first_ff) begin
         hdr_ok_in     = (in_byte_ff == bop_pkg::HdrPlainV2);
         stopped_in    = 1'b0;
         obj_cnt_in    = 9'd0;
         obj_len_in    = 9'd0;
         obj_data_in   = 16'd0;
         end_status_in = hdr_ok_in ? bop_pkg::StatusOk : bop_pkg::StatusBadHeader;
      end else if (hdr_ok_ff && !stopped_ff) begin
         if (obj_cnt_ff == 9'd0) begin
            // type byte
            if (in_byte_ff >= bop_pkg::TypeLimit) begin
               stopped_in    = 1'b1;
               end_status_in = bop_pkg::StatusUnknown;
            end else begin
               obj_type_in = in_byte_ff;
               obj_data_in = 16'd0;
               obj_len_in  = (type_len == bop_pkg::LenVariable) ? 9'd0
                                                                : {5'b0, type_len} + 9'd1;
               // empty objects never open
               obj_cnt_in  = (type_len == 4'd0) ? 9'd0 : 9'd1;
            end
         end else begin
            if (cnt_next == 9'd2) begin
               obj_data_in = {8'b0, in_byte_ff};
               if (bop_pkg::obj_len(obj_type_ff) == bop_pkg::LenVariable) begin
                  obj_len_in = {1'b0, in_byte_ff} + 9'd2;
               end
            end else if (cnt_next == 9'd3) begin
               obj_data_in = obj_data_ff | {in_byte_ff, 8'b0};
            end
            if (cnt_next == obj_len_in) begin
               upd        = meas.hit;
               obj_cnt_in = 9'd0;
            end else begin
               obj_cnt_in = cnt_next;
            end
         end
      end

      if (32'(in_slot_ff) >= SLOT_COUNT) begin
         upd = 1'b0;
      end

      if (in_last_ff) begin
         if (!hdr_ok_in) begin
            status = bop_pkg::StatusBadHeader;
         end else if (stopped_in) begin
            status = bop_pkg::StatusUnknown;
         end else if (obj_cnt_in != 9'd0) begin
            status = bop_pkg::StatusTruncated;
         end else begin
            status = end_status_in;
         end
         hdr_ok_in     = 1'b0;
         stopped_in    = 1'b0;
         obj_cnt_in    = 9'd0;
         obj_len_in    = 9'd0;
         end_status_in = bop_pkg::StatusBadHeader;
      end
   end

   assign emit = upd | in_last_ff;

   always_comb begin
      if (advance) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         hdr_ok_ff     <= 1'b0;
         stopped_ff    <= 1'b0;
         obj_type_ff   <= 8'd0;
         obj_len_ff    <= 9'd0;
         obj_cnt_ff    <= 9'd0;
         obj_data_ff   <= 16'd0;
         end_status_ff <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            hdr_ok_ff     <= hdr_ok_in;
            stopped_ff    <= stopped_in;
            obj_type_ff   <= obj_type_in;
            obj_len_ff    <= obj_len_in;
            obj_cnt_ff    <= obj_cnt_in;
            obj_data_ff   <= obj_data_in;
            end_status_ff <= end_status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
         in_slot_ff  <= req_sensor_slot;
      end
      if (advance && emit) begin
         out_upd_ff    <= upd;
         out_slot_ff   <= in_slot_ff;
         out_qty_ff    <= upd ? meas.qty : 2'd0;
         out_value_ff  <= upd ? meas.value : 16'd0;
         out_end_ff    <= in_last_ff;
         out_status_ff <= in_last_ff ? status : bop_pkg::StatusOk;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_update_valid   = out_upd_ff;
   assign rsp_update_slot    = out_slot_ff;
   assign rsp_quantity       = out_qty_ff;
   assign rsp_measured_value = out_value_ff;
   assign rsp_packet_end     = out_end_ff;
   assign rsp_packet_status  = out_status_ff;

endmodule
`default_nettype wire

// ===== src/bop_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bop_checker
// Port-level checks on the parser's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module bop_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_update_valid,
   input wire logic [1:0]  rsp_update_slot,
   input wire logic [1:0]  rsp_quantity,
   input wire logic [15:0] rsp_measured_value,
   input wire logic        rsp_packet_end,
   input wire logic [1:0]  rsp_packet_status
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_update_valid)
         && $stable(rsp_update_slot) && $stable(rsp_quantity)
         && $stable(rsp_measured_value) && $stable(rsp_packet_end)
         && $stable(rsp_packet_status))
      else $error("result beat changed while stalled");

   // every beat carries an update, a packet end or both
   a_rsp_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_update_valid || rsp_packet_end)
      else $error("empty result beat");

   a_no_upd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_update_valid |-> rsp_quantity == 2'd0
         && rsp_measured_value == 16'd0)
      else $error("measurement fields set without an update");

   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_packet_end |-> rsp_packet_status == bop_pkg::StatusOk)
      else $error("packet status set without a packet end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind bthome_object_parser bop_checker u_bop_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_update_valid   (rsp_update_valid),
   .rsp_update_slot    (rsp_update_slot),
   .rsp_quantity       (rsp_quantity),
   .rsp_measured_value (rsp_measured_value),
   .rsp_packet_end     (rsp_packet_end),
   .rsp_packet_status  (rsp_packet_status)
);
`default_nettype wire

// ===== sim/tb_bthome_object_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bthome_object_parser
// Drives BTHome v2 payload bytes into the object parser: a short directed set
// of headers, measurement objects, unknown types, cut-off objects and
// restarts, then random packets under four idle/stall mixes and one long
// receiver hold-off. A predictor in the bench works out each result beat and
// a checker compares every beat that leaves the block, field by field.
// ----------------------------------------------------------------------------
module tb_bthome_object_parser;

   localparam int SlotCount  = 4;
   localparam int QuietLimit = 2000;
   localparam int LongHold   = 200;

   // data bytes that follow each object type; LenVariable: length byte follows
   localparam logic [3:0] DataLenLut [0:96] = '{
      4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2,
      4'd2, 4'd1, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1,
      4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 4'd2, 4'd4, 4'd2,
      4'd2, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd4, 4'd2, 4'd2, 4'd15, 4'd15, 4'd4, 4'd2, 4'd1,
      4'd1, 4'd1, 4'd2, 4'd4, 4'd4, 4'd2, 4'd2, 4'd2,
      4'd1
   };

   localparam logic [7:0] MeasTypes [0:7] = '{
      bop_pkg::TypeTemp, bop_pkg::TypeTempX10, bop_pkg::TypeTempS8,
      bop_pkg::TypeTempS8X35, bop_pkg::TypeHumid, bop_pkg::TypeHumidU8,
      bop_pkg::TypeBattery, bop_pkg::TypeVolt
   };

   typedef struct packed {
      logic        upd;
      logic [1:0]  slot;
      logic [1:0]  qty;
      logic [15:0] value;
      logic        pkt_end;
      logic [1:0]  status;
   } sensor_report_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic [1:0]  req_sensor_slot;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_update_valid;
   logic [1:0]  rsp_update_slot;
   logic [1:0]  rsp_quantity;
   logic [15:0] rsp_measured_value;
   logic        rsp_packet_end;
   logic [1:0]  rsp_packet_status;

   // parser state as the bench sees it
   logic        hdr_ok       = 1'b0;
   logic        stopped      = 1'b0;
   logic [7:0]  cur_type     = 8'h00;
   logic [8:0]  cur_len      = 9'd0;
   logic [8:0]  cur_count    = 9'd0;
   logic [15:0] cur_data     = 16'h0000;
   logic [1:0]  pend_status  = bop_pkg::StatusOk;

   sensor_report_type due_reports[$];

   int fault_count    = 0;
   int bytes_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int quiet_cycles   = 0;

   bthome_object_parser #(
      .SLOT_COUNT(SlotCount)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .req_sensor_slot    (req_sensor_slot),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_update_valid   (rsp_update_valid),
      .rsp_update_slot    (rsp_update_slot),
      .rsp_quantity       (rsp_quantity),
      .rsp_measured_value (rsp_measured_value),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_packet_status  (rsp_packet_status)
   );

   always #5 clock = ~clock;

   // works out the report, if any, that one accepted byte gives
   function automatic void decode_byte(input logic [7:0] b, input logic first,
                                       input logic last, input logic [1:0] slot);
      logic              upd;
      logic [1:0]        qty;
      logic [31:0]       val;
      logic [1:0]        st;
      logic [3:0]        n;
      sensor_report_type r;
      upd = 1'b0;
      qty = bop_pkg::QtyTemp;
      val = 32'd0;
      st  = bop_pkg::StatusOk;
      if (first) begin
         hdr_ok      = (b == bop_pkg::HdrPlainV2);
         stopped     = 1'b0;
         cur_count   = 9'd0;
         cur_len     = 9'd0;
         cur_data    = 16'h0000;
         pend_status = hdr_ok ? bop_pkg::StatusOk : bop_pkg::StatusBadHeader;
      end else if (hdr_ok && !stopped) begin
         if (cur_count == 9'd0) begin
            if (b >= bop_pkg::TypeLimit) begin
               stopped     = 1'b1;
               pend_status = bop_pkg::StatusUnknown;
            end else begin
               n         = DataLenLut[b[6:0]];
               cur_type  = b;
               cur_data  = 16'h0000;
               cur_len   = (n == bop_pkg::LenVariable) ? 9'd0 : 9'(n) + 9'd1;
               // objects with no data bytes close on their type byte
               cur_count = (cur_len == 9'd1) ? 9'd0 : 9'd1;
            end
         end else begin
            cur_count = cur_count + 9'd1;
            if (cur_count == 9'd2) begin
               cur_data = {8'h00, b};
               if (DataLenLut[cur_type[6:0]] == bop_pkg::LenVariable) begin
                  cur_len = 9'(b) + 9'd2;
               end
            end else if (cur_count == 9'd3) begin
               cur_data[15:8] = b;
            end
            if (cur_count == cur_len) begin
               upd = 1'b1;
               case (cur_type)
                  bop_pkg::TypeTemp:      val = 32'(cur_data);
                  bop_pkg::TypeTempX10:   val = 32'(cur_data) * 32'd10;
                  bop_pkg::TypeTempS8:
                     val = {{24{cur_data[7]}}, cur_data[7:0]} * 32'd100;
                  bop_pkg::TypeTempS8X35:
                     val = {{24{cur_data[7]}}, cur_data[7:0]} * 32'd35;
                  bop_pkg::TypeHumid: begin
                     qty = bop_pkg::QtyHumid;
                     val = 32'(cur_data);
                  end
                  bop_pkg::TypeHumidU8: begin
                     qty = bop_pkg::QtyHumid;
                     val = 32'(cur_data[7:0]) * 32'd100;
                  end
                  bop_pkg::TypeBattery: begin
                     qty = bop_pkg::QtyBattery;
                     val = 32'(cur_data[7:0]);
                  end
                  bop_pkg::TypeVolt: begin
                     qty = bop_pkg::QtyVolt;
                     val = 32'(cur_data) / 32'd100;
                  end
                  default: upd = 1'b0;
               endcase
               cur_count = 9'd0;
            end
         end
      end
      if (32'(slot) >= SlotCount) begin
         upd = 1'b0;
      end
      if (last) begin
         if (!hdr_ok) begin
            st = bop_pkg::StatusBadHeader;
         end else if (stopped) begin
            st = bop_pkg::StatusUnknown;
         end else if (cur_count != 9'd0) begin
            st = bop_pkg::StatusTruncated;
         end else begin
            st = pend_status;
         end
         hdr_ok      = 1'b0;
         stopped     = 1'b0;
         cur_count   = 9'd0;
         cur_len     = 9'd0;
         pend_status = bop_pkg::StatusBadHeader;
      end
      if (upd || last) begin
         r.upd     = upd;
         r.slot    = slot;
         r.qty     = upd ? qty : bop_pkg::QtyTemp;
         r.value   = upd ? val[15:0] : 16'h0000;
         r.pkt_end = last;
         r.status  = last ? st : bop_pkg::StatusOk;
         due_reports.push_back(r);
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         default: return 8'($urandom);
      endcase
   endfunction

   // one beat on the byte channel; valid stays high after acceptance
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic [1:0] slot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_first_byte  <= first;
      req_last_byte   <= last;
      req_sensor_slot <= slot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      decode_byte(b, first, last, slot);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] bytes[$], input logic [1:0] slot,
                              input bit close);
      foreach (bytes[i]) begin
         send_byte(bytes[i], i == 0, close && (i == bytes.size() - 1), slot);
      end
   endtask

   task automatic send_random_packet();
      logic [7:0] body[$];
      logic [7:0] t;
      logic [1:0] slot;
      int         len;
      int         kind;
      int         cut;
      slot = 2'($urandom_range(3));
      if ($urandom_range(11) == 0) begin
         // stray byte, outside any packet unless the last one was left open
         send_byte(rand_byte(), 1'b0, 1'($urandom_range(1)), 2'($urandom_range(3)));
      end
      body.push_back(($urandom_range(9) == 0) ? rand_byte() : bop_pkg::HdrPlainV2);
      repeat ($urandom_range(5)) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            t = MeasTypes[$urandom_range(7)];
         end else if (kind < 93) begin
            t = 8'($urandom_range(8'h60));
         end else begin
            t = 8'($urandom_range(255, 8'h61));
         end
         body.push_back(t);
         if (t < bop_pkg::TypeLimit) begin
            if (DataLenLut[t[6:0]] == bop_pkg::LenVariable) begin
               len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
               body.push_back(8'(len));
            end else begin
               len = DataLenLut[t[6:0]];
            end
            repeat (len) body.push_back(rand_byte());
         end
      end
      if (body.size() > 1 && $urandom_range(7) == 0) begin
         cut = $urandom_range(body.size() - 1, 1);
         repeat (cut) void'(body.pop_back());
      end
      // now and then the packet is left open and the next header restarts it
      send_packet(body, slot, $urandom_range(15) != 0);
   endtask

   task automatic test_headers();
      send_byte(8'h44, 1'b1, 1'b1, 2'd0);                  // header other than the plain v2 form
      send_byte(bop_pkg::HdrPlainV2, 1'b1, 1'b1, 2'd3);    // header-only packet
      send_byte(8'ha5, 1'b0, 1'b1, 2'd2);                  // stray end mark
      send_packet({8'h00, bop_pkg::TypeTemp}, 2'd1, 1'b1); // body after a rejected header
   endtask

   task automatic test_measurements();
      send_packet({bop_pkg::HdrPlainV2, bop_pkg::TypeTemp, 8'h00, 8'h80,
                   bop_pkg::TypeTempX10, 8'hff, 8'h7f, bop_pkg::TypeTempS8, 8'h80,
                   bop_pkg::TypeTempS8X35, 8'h81}, 2'd2, 1'b1);
      // unknown type ends the packet with the stop status
      send_packet({bop_pkg::HdrPlainV2, bop_pkg::TypeHumid, 8'hff, 8'hff,
                   bop_pkg::TypeHumidU8, 8'hff, bop_pkg::TypeBattery, 8'h64, 8'h61},
                  2'd1, 1'b1);
   endtask

   task automatic test_restart_and_truncation();
      // variable-length object interrupted by a new header
      send_packet({bop_pkg::HdrPlainV2, 8'h54, 8'h02, 8'haa}, 2'd0, 1'b0);
      // battery type byte with no data at the end of the packet
      send_packet({bop_pkg::HdrPlainV2, bop_pkg::TypeVolt, 8'hff, 8'hff,
                   bop_pkg::TypeBattery}, 2'd0, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_bytes);
      int stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         send_random_packet();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (10) begin
         send_packet({bop_pkg::HdrPlainV2, bop_pkg::TypeTemp, rand_byte(), rand_byte(),
                      bop_pkg::TypeBattery, rand_byte()}, 2'($urandom_range(3)), 1'b1);
      end
   endtask

   // receiver side: random stalls, or a long hold when one is asked for
   always @(negedge clock) begin : drive_rsp_stall
      int holds_started = 0;
      int hold_left     = 0;
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left     = LongHold;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : check_reports
      sensor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            $error("result beat with nothing outstanding: update_valid %0b packet_end %0b",
                   rsp_update_valid, rsp_packet_end);
            fault_count++;
         end else begin
            want = due_reports.pop_front();
            compare_field("update_valid", want.upd, rsp_update_valid);
            compare_field("update_slot", want.slot, rsp_update_slot);
            compare_field("quantity", want.qty, rsp_quantity);
            compare_field("measured_value", want.value, rsp_measured_value);
            compare_field("packet_end", want.pkt_end, rsp_packet_end);
            compare_field("packet_status", want.status, rsp_packet_status);
         end
      end
   end

   // ends the run when neither channel has moved a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'h00;
      req_first_byte  = 1'b0;
      req_last_byte   = 1'b0;
      req_sensor_slot = 2'd0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_headers();
      test_measurements();
      test_restart_and_truncation();
      test_random_traffic(0, 0, 320);
      test_random_traffic(61, 0, 320);
      test_random_traffic(0, 61, 320);
      test_random_traffic(17, 17, 320);
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_reports.size() != 0) begin
         @(posedge clock);
      end
      // two-stage pipeline; leave room for any stray beat to show up
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
